// ===== src/vbyte_integer_codec_defines.svh =====
// ----------------------------------------------------------------------------
// vbyte integer codec assertion macros
// Shared concurrent assertion forms; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef VBYTE_INTEGER_CODEC_DEFINES_SVH
`define VBYTE_INTEGER_CODEC_DEFINES_SVH

// same-cycle implication, disabled during reset
`define VBIC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define VBIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/vbic_pkg.sv =====
// ----------------------------------------------------------------------------
// vbic_pkg
// Widths, codes and the job type shared by the vbyte integer codec.
// ----------------------------------------------------------------------------
`default_nettype none

package vbic_pkg;

  // field widths
  localparam int ENC_WIDTH  = 64;
  localparam int DEC_WIDTH  = 32;
  localparam int BYTE_W     = 8;
  localparam int GRP_BITS   = 7;
  localparam int ENC_GROUPS = (ENC_WIDTH + GRP_BITS - 1) / GRP_BITS;
  localparam int LEN_W      = 4;

  // decode state
  localparam int ACC_W     = 28;
  localparam int DEC_BYTES = 5;
  localparam int IDX_W     = 3;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  // one unit of work for the back end
  typedef struct packed {
    dir_t                 mode;
    logic [ENC_WIDTH-1:0] data;
    logic [LEN_W-1:0]     len;
  } job_t;

endpackage

`default_nettype wire

// ===== src/vbic_if.sv =====
// ----------------------------------------------------------------------------
// vbic channel interfaces
// Valid/ready channels for input items and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface vbic_in_if;
  import vbic_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ENC_WIDTH-1:0] enc_value;
  logic [BYTE_W-1:0]    dec_byte;

  modport source (output valid, output enc_value, output dec_byte, input ready);
  modport sink   (input valid, input enc_value, input dec_byte, output ready);
endinterface

interface vbic_out_if;
  import vbic_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [BYTE_W-1:0]    out_byte;
  logic [DEC_WIDTH-1:0] out_value;
  logic [LEN_W-1:0]     encoded_length;
  logic                 last;

  modport source (output valid, output out_byte, output out_value,
                  output encoded_length, output last, input ready);
  modport sink   (input valid, input out_byte, input out_value,
                  input encoded_length, input last, output ready);
endinterface

`default_nettype wire

// ===== src/vbic_front.sv =====
// ----------------------------------------------------------------------------
// vbic_front
// Accepts input words, holds the direction register and the decode
// accumulator, and turns each encode value or completed decode value into a job for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vbyte_integer_codec_defines.svh"

module vbic_front (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   cfg_we,
  input  wire logic   cfg_wdata,
  vbic_in_if.sink     in_ch,
  input  wire logic   q_full,
  output logic        push,
  output vbic_pkg::job_t push_job
);
  import vbic_pkg::*;

  dir_t             dir_r;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [IDX_W-1:0] byte_idx_r, byte_idx_nxt;

  logic                 accept;
  logic [IDX_W-1:0]     idx_eff;
  logic                 term;
  logic [DEC_WIDTH+GRP_BITS-1:0] merged;

  // minimal byte count: one plus each nonzero higher group boundary
  function automatic logic [LEN_W-1:0] enc_length(logic [ENC_WIDTH-1:0] v);
    logic [LEN_W-1:0] n;
    n = LEN_W'(1);
    for (int k = 1; k < ENC_GROUPS; k++) begin
      if ((v >> (GRP_BITS * k)) != '0) n = n + 1'b1;
    end
    return n;
  endfunction

  // direction register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_ENCODE;
    end else if (cfg_we) begin
      dir_r <= dir_t'(cfg_wdata);
    end
  end

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // merge the new group into the accumulator
  always_comb begin
    idx_eff = (byte_idx_r >= IDX_W'(DEC_BYTES - 1)) ? IDX_W'(DEC_BYTES - 1) : byte_idx_r;
    term    = in_ch.dec_byte[BYTE_W-1] || (idx_eff == IDX_W'(DEC_BYTES - 1));
    merged  = (DEC_WIDTH+GRP_BITS)'(acc_r)
            | ((DEC_WIDTH+GRP_BITS)'(in_ch.dec_byte[GRP_BITS-1:0]) << (GRP_BITS * idx_eff));
  end

  // classify the item and build its job
  always_comb begin
    acc_nxt      = acc_r;
    byte_idx_nxt = byte_idx_r;
    push         = 1'b0;
    push_job     = '0;
    if (accept) begin
      if (dir_r == DIR_ENCODE) begin
        push          = 1'b1;
        push_job.mode = DIR_ENCODE;
        push_job.data = in_ch.enc_value;
        push_job.len  = enc_length(in_ch.enc_value);
      end else if (term) begin
        push          = 1'b1;
        push_job.mode = DIR_DECODE;
        push_job.data = ENC_WIDTH'(merged[DEC_WIDTH-1:0]);
        push_job.len  = '0;
        acc_nxt       = '0;
        byte_idx_nxt  = '0;
      end else begin
        acc_nxt      = merged[ACC_W-1:0];
        byte_idx_nxt = idx_eff + 1'b1;
      end
    end
  end

  // decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      byte_idx_r <= '0;
    end else begin
      acc_r      <= acc_nxt;
      byte_idx_r <= byte_idx_nxt;
    end
  end

  `VBIC_ASSERT(a_idx_range, 1'b1, byte_idx_r < IDX_W'(DEC_BYTES), "decode byte index out of range")

endmodule

`default_nettype wire

// ===== src/vbic_queue.sv =====
// ----------------------------------------------------------------------------
// vbic_queue
// Short job queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vbyte_integer_codec_defines.svh"

module vbic_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire vbic_pkg::job_t  push_job,
  output logic                 full,
  input  wire logic            pop,
  output logic                 pop_valid,
  output vbic_pkg::job_t       pop_job
);
  import vbic_pkg::*;

  job_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] count_r, count_nxt;

  assign full      = (count_r == Q_CW'(Q_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_job   = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  `VBIC_ASSERT(a_no_overflow, push, !full, "push into full queue")
  `VBIC_ASSERT(a_no_underflow, pop, pop_valid, "pop from empty queue")
  `VBIC_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1, "count did not grow")

endmodule

`default_nettype wire

// ===== src/vbic_back.sv =====
// ----------------------------------------------------------------------------
// vbic_back
// Carries out jobs: splits encode values into bytes, one per cycle while the
// receiver is ready, and passes decoded values through, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vbyte_integer_codec_defines.svh"

module vbic_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire vbic_pkg::job_t  q_job,
  output logic                 pop,
  vbic_out_if.source           out_ch
);
  import vbic_pkg::*;

  // job in progress
  logic             cur_valid_r, cur_valid_nxt;
  job_t             cur_r, cur_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;

  // output stage
  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]    out_byte_r, out_byte_nxt;
  logic [DEC_WIDTH-1:0] out_value_r, out_value_nxt;
  logic [LEN_W-1:0]     out_len_r, out_len_nxt;
  logic                 out_last_r, out_last_nxt;

  logic out_load, emit, final_word;

  assign out_load   = !out_valid_r || out_ch.ready;
  assign emit       = out_load && cur_valid_r;
  assign final_word = (rem_r == LEN_W'(1));
  assign pop        = q_valid && (!cur_valid_r || (emit && final_word));

  // advance the current job and load the next
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    rem_nxt       = rem_r;
    if (emit && !final_word) begin
      cur_nxt.data = cur_r.data >> GRP_BITS;
      rem_nxt      = rem_r - 1'b1;
    end
    if (emit && final_word) cur_valid_nxt = 1'b0;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      cur_nxt       = q_job;
      rem_nxt       = (q_job.mode == DIR_DECODE) ? LEN_W'(1) : q_job.len;
    end
  end

  // build the next output word
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_value_nxt = out_value_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (cur_r.mode == DIR_DECODE) begin
        out_byte_nxt  = '0;
        out_value_nxt = cur_r.data[DEC_WIDTH-1:0];
        out_len_nxt   = '0;
        out_last_nxt  = 1'b1;
      end else begin
        out_byte_nxt  = {final_word, cur_r.data[GRP_BITS-1:0]};
        out_value_nxt = '0;
        out_len_nxt   = cur_r.len;
        out_last_nxt  = final_word;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    rem_r       <= rem_nxt;
    out_byte_r  <= out_byte_nxt;
    out_value_r <= out_value_nxt;
    out_len_r   <= out_len_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_byte       = out_byte_r;
  assign out_ch.out_value      = out_value_r;
  assign out_ch.encoded_length = out_len_r;
  assign out_ch.last           = out_last_r;

  `VBIC_ASSERT(a_rem_range, cur_valid_r && (cur_r.mode == DIR_ENCODE),
               (rem_r != '0) && (rem_r <= cur_r.len), "byte count outside job length")
  `VBIC_ASSERT(a_dec_last, out_valid_r && (out_len_r == '0), out_last_r,
               "decoded word without last")

endmodule

`default_nettype wire

// ===== src/vbyte_integer_codec.sv =====
// ----------------------------------------------------------------------------
// vbyte_integer_codec
// Variable-byte integer encoder and decoder, seven data bits per byte.
// ----------------------------------------------------------------------------
// in_ch carries one item per word: enc_value is used in encode mode,
// dec_byte in decode mode. out_ch carries one result per word.
// cfg_we/cfg_wdata write the direction bit (0 encode, 1 decode); write it
// only while no result is pending.
// Encode: a value gives 1 to 10 byte words, the final one with bit 7 and
// last set. Decode: bytes gather into a 32-bit value that leaves as one
// word when a byte with bit 7 set, or the fifth byte, arrives.
// The first result word of an item passes through the job queue, the
// current-job register and the output register. Throughput: one output
// word per cycle from the back end while the receiver is ready, and
// decode takes one byte per cycle while the job queue is not full.
// A four-entry job queue sits between the front and back ends; when the
// receiver stalls, the output register holds and the queue fills, and
// in_ch.ready drops only when the queue is full.
// Reset clears the direction to encode, the decode state and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vbyte_integer_codec (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  vbic_in_if.sink    in_ch,
  vbic_out_if.source out_ch
);
  import vbic_pkg::*;

  logic push, q_full, pop, q_valid;
  job_t push_job, q_job;

  // classify items and keep decode state
  vbic_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // job queue
  vbic_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_valid(q_valid),
    .pop_job  (q_job)
  );

  // emit result words
  vbic_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_valid(q_valid),
    .q_job  (q_job),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ===== bench/vbyte_integer_codec_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vbyte_integer_codec_test
// Drives input words and checks result words of the variable-byte codec.
// A directed table covers the field extremes, early and late terminate
// bytes, the forced end on the fifth byte and a direction change in the
// middle of a value. Random phases then alternate encode and decode, with
// mostly well-formed byte sequences and some noise. An in-bench predictor
// keeps its own direction and partial-value state, and a scoreboard
// compares every result word field by field. Both sides idle at random,
// and one long receiver stall fills the job queue.
// ----------------------------------------------------------------------------

module vbyte_integer_codec_test;
  import vbic_pkg::*;

  localparam int          PHASES         = 6;
  localparam int          PHASE_ITEMS    = 42;
  localparam int          SETTLE_CYCLES  = 12;
  localparam int          HOLD_CYCLES    = 80;
  localparam int          WATCHDOG_LIMIT = 1000;
  localparam int          MAX_GAP        = 18;
  localparam int          MAX_LEN        = 10;

  // one result word as the block should present it
  typedef struct packed {
    logic [BYTE_W-1:0]    code_byte;
    logic [DEC_WIDTH-1:0] value;
    logic [LEN_W-1:0]     len;
    logic                 last;
  } codec_word_t;

  // one row of the directed table; typed rows carry their own result
  typedef struct packed {
    dir_t                 dir;
    logic [ENC_WIDTH-1:0] enc;
    logic [BYTE_W-1:0]    dec;
    logic                 typed;
    logic [BYTE_W-1:0]    t_byte;
    logic [DEC_WIDTH-1:0] t_value;
    logic [LEN_W-1:0]     t_len;
  } stim_row_t;

  localparam int ROWS = 23;

  stim_row_t dir_rows [ROWS] = '{
    // encode extremes and length boundaries
    '{DIR_ENCODE, 64'd0,                  8'h00, 1'b1, 8'h80, 32'd0, 4'd1},
    '{DIR_ENCODE, 64'd127,                8'h00, 1'b1, 8'hff, 32'd0, 4'd1},
    '{DIR_ENCODE, 64'd128,                8'h00, 1'b0, 8'h00, 32'd0, 4'd0},
    '{DIR_ENCODE, 64'd16383,              8'h00, 1'b0, 8'h00, 32'd0, 4'd0},
    '{DIR_ENCODE, 64'd16384,              8'h00, 1'b0, 8'h00, 32'd0, 4'd0},
    '{DIR_ENCODE, 64'h0100_0000_0000_0000, 8'h00, 1'b0, 8'h00, 32'd0, 4'd0},
    '{DIR_ENCODE, 64'h8000_0000_0000_0000, 8'h00, 1'b0, 8'h00, 32'd0, 4'd0},
    '{DIR_ENCODE, 64'hffff_ffff_ffff_ffff, 8'h00, 1'b0, 8'h00, 32'd0, 4'd0},
    // single terminate bytes
    '{DIR_DECODE, 64'd0, 8'h80, 1'b1, 8'h00, 32'd0,   4'd0},
    '{DIR_DECODE, 64'd0, 8'hff, 1'b1, 8'h00, 32'd127, 4'd0},
    // fifth byte ends the value with its terminate bit clear
    '{DIR_DECODE, 64'd0, 8'h7f, 1'b0, 8'h00, 32'd0, 4'd0},
    '{DIR_DECODE, 64'd0, 8'h7f, 1'b0, 8'h00, 32'd0, 4'd0},
    '{DIR_DECODE, 64'd0, 8'h7f, 1'b0, 8'h00, 32'd0, 4'd0},
    '{DIR_DECODE, 64'd0, 8'h7f, 1'b0, 8'h00, 32'd0, 4'd0},
    '{DIR_DECODE, 64'd0, 8'h7f, 1'b1, 8'h00, 32'hffff_ffff, 4'd0},
    // fifth byte with terminate set, upper data bits dropped
    '{DIR_DECODE, 64'd0, 8'h00, 1'b0, 8'h00, 32'd0, 4'd0},
    '{DIR_DECODE, 64'd0, 8'h00, 1'b0, 8'h00, 32'd0, 4'd0},
    '{DIR_DECODE, 64'd0, 8'h00, 1'b0, 8'h00, 32'd0, 4'd0},
    '{DIR_DECODE, 64'd0, 8'h00, 1'b0, 8'h00, 32'd0, 4'd0},
    '{DIR_DECODE, 64'd0, 8'hff, 1'b1, 8'h00, 32'hf000_0000, 4'd0},
    // partial value survives an encode detour
    '{DIR_DECODE, 64'd0,   8'h05, 1'b0, 8'h00, 32'd0, 4'd0},
    '{DIR_ENCODE, 64'd300, 8'h00, 1'b0, 8'h00, 32'd0, 4'd0},
    '{DIR_DECODE, 64'd0,   8'h81, 1'b0, 8'h00, 32'd0, 4'd0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  vbic_in_if  in_bus ();
  vbic_out_if out_bus ();

  vbyte_integer_codec uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  // predictor state
  dir_t              cur_dir = DIR_ENCODE;
  logic [ACC_W-1:0]  acc_groups = '0;
  logic [IDX_W-1:0]  acc_count = '0;

  codec_word_t pending_words [$];
  codec_word_t head_word;
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          offered = 0;
  bit          send_busy = 1'b0;
  bit          hold_out = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // words a single accepted item produces; state moves even when not queued
  task automatic predict_item(input logic [ENC_WIDTH-1:0] value_in,
                              input logic [BYTE_W-1:0] byte_in, input bit queue_it);
    int unsigned       n_bytes;
    logic [63:0]       grp;
    logic [63:0]       merged;
    codec_word_t       w;
    if (cur_dir == DIR_ENCODE) begin
      n_bytes = 1;
      while (n_bytes < MAX_LEN && (value_in >> (GRP_BITS * n_bytes)) != 0) n_bytes++;
      for (int i = 0; i < n_bytes; i++) begin
        grp         = value_in >> (GRP_BITS * i);
        w.code_byte = {(i == n_bytes - 1), grp[GRP_BITS-1:0]};
        w.value     = '0;
        w.len       = LEN_W'(n_bytes);
        w.last      = (i == n_bytes - 1);
        if (queue_it) pending_words.push_back(w);
      end
    end else begin
      merged = 64'(acc_groups) | (64'(byte_in[GRP_BITS-1:0]) << (GRP_BITS * acc_count));
      if (byte_in[7] || acc_count == DEC_BYTES - 1) begin
        w.code_byte = '0;
        w.value     = merged[DEC_WIDTH-1:0];
        w.len       = '0;
        w.last      = 1'b1;
        if (queue_it) pending_words.push_back(w);
        acc_groups = '0;
        acc_count  = '0;
      end else begin
        acc_groups = merged[ACC_W-1:0];
        acc_count  = acc_count + 1'b1;
      end
    end
  endtask

  // offer one item after a random gap and record what it should produce
  task automatic offer(input logic [ENC_WIDTH-1:0] value_in, input logic [BYTE_W-1:0] byte_in,
                       input logic typed, input codec_word_t typed_word);
    int                   gap;
    logic [ENC_WIDTH-1:0] v;
    logic [BYTE_W-1:0]    b;
    v = value_in;
    b = byte_in;
    // the field the current mode ignores carries noise
    if (cur_dir == DIR_ENCODE) b = BYTE_W'($urandom);
    else v = {$urandom, $urandom};
    if (offered % 16 == 0) send_busy = ($urandom_range(0, 2) != 0);
    offered++;
    gap = (send_busy && !hold_out) ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.enc_value <= v;
    in_bus.dec_byte  <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predict_item(v, b, !typed);
    if (typed) pending_words.push_back(typed_word);
  endtask

  // stop offering until every expected word is back and the pipe is empty
  task automatic drain_then_settle();
    in_bus.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(input dir_t d);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_dir = d;
  endtask

  task automatic check_field(input string what, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
      mismatches++;
    end
  endtask

  // receiver: random stalls per word, plus one long hold on request
  initial begin
    int  gap;
    int  taken;
    bit  recv_busy;
    taken     = 0;
    recv_busy = 1'b0;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_out) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        if (taken % 16 == 0) recv_busy = ($urandom_range(0, 2) != 0);
        gap = recv_busy ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
          out_bus.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
      taken++;
    end
  end

  // scoreboard on every accepted result word
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual byte %0h value %0h len %0d last %0b",
                 $time, out_bus.out_byte, out_bus.out_value, out_bus.encoded_length,
                 out_bus.last);
        mismatches++;
      end else begin
        head_word = pending_words.pop_front();
        check_field("out_byte", 64'(head_word.code_byte), 64'(out_bus.out_byte));
        check_field("out_value", 64'(head_word.value), 64'(out_bus.out_value));
        check_field("encoded_length", 64'(head_word.len), 64'(out_bus.encoded_length));
        check_field("last", 64'(head_word.last), 64'(out_bus.last));
      end
    end
  end

  // cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAIL vbyte_integer_codec");
    $finish;
  end

  // stimulus
  initial begin
    int                   sent;
    int                   nbits;
    int                   seq_len;
    logic [ENC_WIDTH-1:0] v;
    logic [BYTE_W-1:0]    b;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.enc_value <= '0;
    in_bus.dec_byte  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int r = 0; r < ROWS; r++) begin
      if (dir_rows[r].dir != cur_dir) begin
        drain_then_settle();
        write_direction(dir_rows[r].dir);
      end
      offer(dir_rows[r].enc, dir_rows[r].dec, dir_rows[r].typed,
            '{dir_rows[r].t_byte, dir_rows[r].t_value, dir_rows[r].t_len, 1'b1});
    end

    // random phases, alternating direction
    for (int p = 0; p < PHASES; p++) begin
      drain_then_settle();
      write_direction(p % 2 == 0 ? DIR_DECODE : DIR_ENCODE);
      // fill the job queue against a stalled receiver once
      if (p == 1) hold_out = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (cur_dir == DIR_ENCODE) begin
          // spread the value sizes so every encoded length shows up
          nbits = $urandom_range(0, ENC_WIDTH);
          v     = {$urandom, $urandom};
          if (nbits < ENC_WIDTH) v = v & ((64'd1 << nbits) - 1);
          offer(v, '0, 1'b0, '0);
          sent++;
        end else if ($urandom_range(0, 5) == 0) begin
          // noise byte
          b = BYTE_W'($urandom);
          offer('0, b, 1'b0, '0);
          sent++;
        end else begin
          // well-formed value: terminate only on the last byte, which may omit it on the fifth
          seq_len = $urandom_range(1, DEC_BYTES);
          for (int i = 0; i < seq_len; i++) begin
            b = BYTE_W'($urandom);
            if (i == seq_len - 1 && seq_len == DEC_BYTES) b[7] = 1'($urandom);
            else b[7] = (i == seq_len - 1);
            offer('0, b, 1'b0, '0);
            sent++;
          end
        end
      end
    end

    drain_then_settle();
    if (mismatches == 0) begin
      $display("PASS vbyte_integer_codec");
    end else begin
      $display("FAIL vbyte_integer_codec");
    end
    $finish;
  end

endmodule
